// ===== design/hsp_pkg.sv =====
// Shared types, codes and tables for the half-step stepper positioner.
package hsp_pkg;

    localparam int HSP_POSITION_BITS = 16;
    localparam int TICK_BITS         = 11;
    localparam int SPEED_IDX_BITS    = 5;
    localparam int AMP_BITS          = 15;
    localparam int OFFSET_BITS       = 16;
    localparam int TARGET_BITS       = 16;
    localparam int POS_OUT_BITS      = 16;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 15;
    localparam int M_TDATA_BITS      = 40;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_INDEX  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTINUOUS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OSC_ENABLE   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OSC_AMPLITUDE = 2'd3;

    localparam logic [SPEED_IDX_BITS-1:0] SPEED_INDEX_RESET = 5'd8;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_SET_TARGET = 1'b1;

    typedef struct packed {
        logic [SPEED_IDX_BITS-1:0] speed_index;
        logic                      continuous_run;
        logic                      oscillate_enable;
        logic [AMP_BITS-1:0]       oscillate_amplitude;
    } hsp_cfg_t;

    typedef struct packed {
        logic signed [OFFSET_BITS-1:0] oscillation_offset;
        logic [1:0]                    direction;
        logic                          stepped;
        logic [POS_OUT_BITS-1:0]       position;
        logic [3:0]                    coil_pattern;
    } hsp_result_t;

    function automatic logic [TICK_BITS-1:0] speed_compare(
        input logic [SPEED_IDX_BITS-1:0] idx
    );
        logic [TICK_BITS-1:0] val;
        case (idx)
            5'd0:    val = 11'd1099;
            5'd1:    val = 11'd549;
            5'd2:    val = 11'd366;
            5'd3:    val = 11'd275;
            5'd4:    val = 11'd220;
            5'd5:    val = 11'd183;
            5'd6:    val = 11'd157;
            5'd7:    val = 11'd137;
            5'd8:    val = 11'd122;
            5'd9:    val = 11'd110;
            5'd10:   val = 11'd100;
            5'd11:   val = 11'd92;
            5'd12:   val = 11'd85;
            5'd13:   val = 11'd78;
            5'd14:   val = 11'd73;
            5'd15:   val = 11'd69;
            5'd16:   val = 11'd65;
            5'd17:   val = 11'd61;
            default: val = 11'd58;
        endcase
        return val;
    endfunction

    function automatic logic [3:0] half_step_pattern(input logic [2:0] ph);
        logic [3:0] pat;
        case (ph)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1100;
            3'd2:    pat = 4'b0100;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0010;
            3'd5:    pat = 4'b0011;
            3'd6:    pat = 4'b0001;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/hsp_cfg_regs.sv =====
// Configuration register file for the half-step stepper positioner.
module hsp_cfg_regs
    import hsp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output hsp_cfg_t                  cfg
);

    hsp_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_index         <= SPEED_INDEX_RESET;
            cfg_reg.continuous_run      <= 1'b0;
            cfg_reg.oscillate_enable    <= 1'b0;
            cfg_reg.oscillate_amplitude <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SPEED_INDEX:   cfg_reg.speed_index <= cfg_data[SPEED_IDX_BITS-1:0];
                CFG_CONTINUOUS:    cfg_reg.continuous_run <= cfg_data[0];
                CFG_OSC_ENABLE:    cfg_reg.oscillate_enable <= cfg_data[0];
                CFG_OSC_AMPLITUDE: cfg_reg.oscillate_amplitude <= cfg_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== design/hsp_step_core.sv =====
// Tick counter, step decision and motor state of the half-step stepper positioner.
module hsp_step_core
    import hsp_pkg::*;
#(
    parameter int POSITION_BITS = HSP_POSITION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   opcode,
    input  logic [TARGET_BITS-1:0] target_position,
    input  hsp_cfg_t               cfg,
    output hsp_result_t            result
);

    logic [TICK_BITS-1:0]     tick_reg,   tick_next;
    logic [2:0]               phase_reg,  phase_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [POSITION_BITS-1:0] target_reg, target_next;
    logic [1:0]               dir_reg,    dir_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [3:0]               coil_reg,   coil_next;

    logic [POSITION_BITS-1:0] target_in;
    logic [TICK_BITS-1:0]     compare;
    logic [OFFSET_BITS-1:0]   amp_ext;
    logic [OFFSET_BITS-1:0]   offset_neg;
    logic                     reverse;
    logic [1:0]               osc_dir;
    logic                     stepped;

    assign target_in  = POSITION_BITS'(target_position);
    assign compare    = speed_compare(cfg.speed_index);
    assign amp_ext    = OFFSET_BITS'(cfg.oscillate_amplitude);
    assign offset_neg = OFFSET_BITS'(0) - offset_reg;
    assign reverse    = (amp_ext == offset_reg) || (amp_ext == offset_neg);
    assign osc_dir    = reverse ? ((dir_reg == DIR_UP) ? DIR_DOWN : DIR_UP) : dir_reg;

    always_comb begin
        tick_next   = tick_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        dir_next    = dir_reg;
        offset_next = offset_reg;
        coil_next   = coil_reg;
        stepped     = 1'b0;
        if (opcode == OP_SET_TARGET) begin
            target_next = target_in;
            if (target_in > pos_reg) begin
                dir_next = DIR_UP;
            end else if ((target_in < pos_reg) && (target_in != '0)) begin
                dir_next = DIR_DOWN;
            end else begin
                dir_next = DIR_NONE;
            end
        end else if (tick_reg >= compare) begin
            tick_next = '0;
            if ((pos_reg != target_reg) || cfg.continuous_run) begin
                case (dir_reg)
                    DIR_UP: begin
                        stepped    = 1'b1;
                        coil_next  = half_step_pattern(phase_reg);
                        phase_next = phase_reg + 3'd1;
                        if (pos_reg != '1) begin
                            pos_next = pos_reg + POSITION_BITS'(1);
                        end
                    end
                    DIR_DOWN: begin
                        stepped    = 1'b1;
                        coil_next  = half_step_pattern(phase_reg);
                        phase_next = phase_reg - 3'd1;
                        if (pos_reg != '0) begin
                            pos_next = pos_reg - POSITION_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end else if (cfg.oscillate_enable) begin
                dir_next = osc_dir;
                case (osc_dir)
                    DIR_UP: begin
                        stepped     = 1'b1;
                        coil_next   = half_step_pattern(phase_reg);
                        phase_next  = phase_reg + 3'd1;
                        offset_next = offset_reg + OFFSET_BITS'(1);
                    end
                    DIR_DOWN: begin
                        stepped     = 1'b1;
                        coil_next   = half_step_pattern(phase_reg);
                        phase_next  = phase_reg - 3'd1;
                        offset_next = offset_reg - OFFSET_BITS'(1);
                    end
                    default: ;
                endcase
            end
        end else begin
            tick_next = tick_reg + TICK_BITS'(1);
        end
    end

    always_comb begin
        result.coil_pattern       = coil_next;
        result.position           = POS_OUT_BITS'(pos_next);
        result.stepped            = stepped;
        result.direction          = dir_next;
        result.oscillation_offset = offset_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg   <= '0;
            phase_reg  <= '0;
            pos_reg    <= '0;
            target_reg <= '0;
            dir_reg    <= DIR_NONE;
            offset_reg <= '0;
            coil_reg   <= '0;
        end else if (advance) begin
            tick_reg   <= tick_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            dir_reg    <= dir_next;
            offset_reg <= offset_next;
            coil_reg   <= coil_next;
        end
    end

endmodule

// ===== design/stepper_half_step_positioner_unit.sv =====
// Half-step stepper positioner: one tick or set-target item in, one status item out.
// Each input item is held in the input register and then in the result register;
// m_tvalid rises when it reaches the result register.
// Throughput: one item per cycle while m_tready is high; the input register can hold
// one item while the result register waits for m_tready, and one state update is done per item.
// Reset (aresetn low at a clock edge) clears position, target, direction, counters,
// coils and the valid flags of both stream registers; speed_index returns to 8.
module stepper_half_step_positioner_unit
    import hsp_pkg::*;
#(
    parameter int POSITION_BITS = HSP_POSITION_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TARGET_BITS-1:0]    s_tdata,   // target_position[15:0]
    input  logic                      s_tuser,   // opcode[0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // coil_pattern[3:0], position[19:4], stepped[20], direction[22:21],
    // oscillation_offset[38:23], zero pad[39]
    output logic [M_TDATA_BITS-1:0]   m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    hsp_cfg_t    cfg;
    hsp_result_t result;
    hsp_result_t out_reg;

    logic                   in_valid_reg;
    logic                   in_opcode_reg;
    logic [TARGET_BITS-1:0] in_target_reg;
    logic                   out_valid_reg;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.oscillation_offset, out_reg.direction,
                       out_reg.stepped, out_reg.position, out_reg.coil_pattern};

    hsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsp_step_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .opcode          (in_opcode_reg),
        .target_position (in_target_reg),
        .cfg             (cfg),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_opcode_reg <= s_tuser;
            in_target_reg <= s_tdata;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule

// ===== design/hsp_checker.sv =====
// Port-level assertions for the half-step stepper positioner, bound to the top level.
module hsp_checker
    import hsp_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [M_TDATA_BITS-1:0]   m_tdata
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    a_step_drives_coils: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |->
            ($countones(m_tdata[3:0]) == 1) || ($countones(m_tdata[3:0]) == 2))
        else $error("step reported without a half-step coil pattern");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39] == 1'b0) && (m_tdata[22:21] != 2'b11))
        else $error("invalid direction code or pad bit in result");

endmodule

bind stepper_half_step_positioner_unit hsp_checker u_hsp_checker (.*);
